@@ rtl/slfq_pkg.sv @@
// Shared types and constants for the skip-locked FIFO queue.
package slfq_pkg;

	localparam int unsigned PAYLOAD_W = 32;
	localparam int unsigned FLAG_W    = 4;
	localparam int unsigned COUNT_W   = 5;
	localparam int unsigned ACTION_W  = 2;
	localparam int unsigned IN_DATA_W = 40;
	localparam int unsigned OUT_DATA_W = 48;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ENQ = 2'd0,
		ACT_DEQ = 2'd1,
		ACT_REL = 2'd2,
		ACT_NOP = 2'd3
	} act_t;

	// classified command handed from front to back
	typedef struct packed {
		act_t                 action;
		logic [PAYLOAD_W-1:0] payload;
		logic                 guard;    // guarded by a flag that exists
		logic [FLAG_W-1:0]    flag;
		logic                 flag_ok;  // flag index below flag count
	} cmd_t;

	typedef struct packed {
		logic [COUNT_W-1:0]   entry_count;
		logic                 queue_full;
		logic                 queue_empty;
		logic [PAYLOAD_W-1:0] data_out;
		logic                 found;
		logic                 accepted;
	} res_t;

endpackage

@@ rtl/skip_locked_fifo_queue.sv @@
// Top level: bounded FIFO whose dequeue skips entries locked by busy flags.
// Path: an item passes the front register and the command queue, then the back part's
// state machine and result register. A dequeue reads and checks entries from the head,
// then moves each later entry down by a read and a write, each waiting on a registered
// read of the entry memory. The back part runs one item at a time.
// Reset clears the entry count and all busy flags; entry memory is not cleared.
module skip_locked_fifo_queue #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned FLAG_COUNT = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [slfq_pkg::ACTION_W-1:0]   s_tuser,  // action
	input  logic [slfq_pkg::IN_DATA_W-1:0]  s_tdata,  // payload, has_flag, flag_index
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// accepted, found, data_out, queue_empty, queue_full, entry_count
	output logic [slfq_pkg::OUT_DATA_W-1:0] m_tdata
);
	import slfq_pkg::*;

	logic fr_valid;
	logic fr_ready;
	cmd_t fr_cmd;
	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;
	res_t res;

	slfq_front #(
		.FLAG_COUNT(FLAG_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_user  (s_tuser),
		.in_data  (s_tdata),
		.cmd_valid(fr_valid),
		.cmd_ready(fr_ready),
		.cmd      (fr_cmd)
	);

	slfq_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fr_valid),
		.push_ready(fr_ready),
		.push_cmd  (fr_cmd),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_cmd   (q_cmd)
	);

	slfq_back #(
		.DEPTH     (DEPTH),
		.FLAG_COUNT(FLAG_COUNT),
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(q_valid),
		.cmd_ready(q_ready),
		.cmd      (q_cmd),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res      (res)
	);

	assign m_tdata = {7'd0, res};

endmodule

@@ rtl/slfq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module slfq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/slfq_front.sv @@
// Input stage: takes items, decodes and classifies them into commands.
module slfq_front #(
	parameter int unsigned FLAG_COUNT = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [slfq_pkg::ACTION_W-1:0]  in_user,
	input  logic [slfq_pkg::IN_DATA_W-1:0] in_data,
	output logic                           cmd_valid,
	input  logic                           cmd_ready,
	output slfq_pkg::cmd_t                 cmd
);
	import slfq_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_dec;
	logic [FLAG_W-1:0] flag_in;

	assign flag_in = in_data[PAYLOAD_W+FLAG_W:PAYLOAD_W+1];

	always_comb begin
		cmd_dec.action  = act_t'(in_user);
		cmd_dec.payload = in_data[PAYLOAD_W-1:0];
		cmd_dec.flag    = flag_in;
		cmd_dec.flag_ok = (32'(flag_in) < FLAG_COUNT);
		// a guard naming a nonexistent flag never blocks the entry
		cmd_dec.guard   = in_data[PAYLOAD_W] && cmd_dec.flag_ok;
	end

	assign in_ready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= cmd_dec;
		end
	end

endmodule

@@ rtl/slfq_cmdq.sv @@
// Two-entry command queue between the front and back parts.
module slfq_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  slfq_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output slfq_pkg::cmd_t pop_cmd
);
	import slfq_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ rtl/slfq_back.sv @@
// Execution part: entry memory, busy flags, head scan and compaction, result register.
module slfq_back #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned FLAG_COUNT = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  slfq_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output slfq_pkg::res_t res
);
	import slfq_pkg::*;

	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(DEPTH + 1);
	localparam int unsigned NFLAG = (FLAG_COUNT < 16) ? FLAG_COUNT : 16;
	localparam int unsigned FW    = (NFLAG > 1) ? $clog2(NFLAG) : 1;
	localparam int unsigned ENT_W = DATA_WIDTH + 1 + FLAG_W;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_SCAN_RD  = 6'b000010,
		ST_SCAN_CHK = 6'b000100,
		ST_SHIFT_RD = 6'b001000,
		ST_SHIFT_WR = 6'b010000,
		ST_RESULT   = 6'b100000
	} bst_t;

	bst_t                  state_q;
	logic [AW-1:0]         idx_q;
	logic [CW-1:0]         count_q;
	logic [NFLAG-1:0]      busy_q;
	logic                  acc_q;
	logic                  found_q;
	logic [DATA_WIDTH-1:0] dout_q;
	logic                  out_valid_q;
	res_t                  out_q;

	logic                  we;
	logic [AW-1:0]         waddr;
	logic [ENT_W-1:0]      wdata;
	logic [AW-1:0]         raddr;
	logic [ENT_W-1:0]      rdata;
	logic [63:0]           pay_ext;
	logic [DATA_WIDTH-1:0] rd_word;
	logic                  rd_guard;
	logic [FLAG_W-1:0]     rd_flag;
	logic                  usable;
	logic [CW:0]           idx_p1;
	logic [CW:0]           idx_p2;
	logic [CW:0]           count_x;
	logic                  is_full;
	logic [15:0]           count_ext;
	logic [63:0]           dout_ext;
	logic                  out_load;

	assign pay_ext  = {32'd0, cmd.payload};
	assign rd_word  = rdata[DATA_WIDTH-1:0];
	assign rd_guard = rdata[DATA_WIDTH];
	assign rd_flag  = rdata[ENT_W-1:DATA_WIDTH+1];
	assign usable   = !rd_guard || !busy_q[rd_flag[FW-1:0]];
	assign idx_p1   = (CW + 1)'(idx_q) + (CW + 1)'(1);
	assign idx_p2   = (CW + 1)'(idx_q) + (CW + 1)'(2);
	assign count_x  = {1'b0, count_q};
	assign is_full  = (count_q == CW'(DEPTH));

	assign cmd_ready = (state_q == ST_IDLE);
	assign out_load  = (state_q == ST_RESULT) && (!out_valid_q || res_ready);

	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = {cmd.flag, cmd.guard, pay_ext[DATA_WIDTH-1:0]};
		raddr = idx_q;
		case (state_q)
			ST_IDLE: begin
				we = cmd_valid && (cmd.action == ACT_ENQ) && !is_full;
			end
			ST_SHIFT_RD: begin
				raddr = idx_p1[AW-1:0];
			end
			ST_SHIFT_WR: begin
				we    = 1'b1;
				waddr = idx_q;
				wdata = rdata;
			end
			default: begin
			end
		endcase
	end

	slfq_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH)
	) u_entries (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			busy_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_RESULT;
						case (cmd.action)
							ACT_ENQ: begin
								if (!is_full) begin
									count_q <= count_q + CW'(1);
								end
							end
							ACT_DEQ: begin
								if (count_q != '0) begin
									state_q <= ST_SCAN_RD;
								end
							end
							ACT_REL: begin
								if (cmd.flag_ok) begin
									busy_q[cmd.flag[FW-1:0]] <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CHK;
				end
				ST_SCAN_CHK: begin
					if (usable) begin
						if (rd_guard) begin
							busy_q[rd_flag[FW-1:0]] <= 1'b1;
						end
						if (idx_p1 < count_x) begin
							state_q <= ST_SHIFT_RD;
						end else begin
							count_q <= count_q - CW'(1);
							state_q <= ST_RESULT;
						end
					end else if (idx_p1 < count_x) begin
						state_q <= ST_SCAN_RD;
					end else begin
						state_q <= ST_RESULT;
					end
				end
				ST_SHIFT_RD: begin
					state_q <= ST_SHIFT_WR;
				end
				ST_SHIFT_WR: begin
					if (idx_p2 < count_x) begin
						state_q <= ST_SHIFT_RD;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-item result fields and scan index
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				idx_q   <= '0;
				found_q <= 1'b0;
				dout_q  <= '0;
				acc_q   <= ((cmd.action == ACT_ENQ) && !is_full) ||
					((cmd.action == ACT_REL) && cmd.flag_ok);
			end
			ST_SCAN_CHK: begin
				if (usable) begin
					found_q <= 1'b1;
					dout_q  <= rd_word;
				end else begin
					idx_q <= idx_p1[AW-1:0];
				end
			end
			ST_SHIFT_WR: begin
				idx_q <= idx_p1[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	assign count_ext = 16'(count_q);
	assign dout_ext  = 64'(dout_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.accepted    <= acc_q;
			out_q.found       <= found_q;
			out_q.data_out    <= dout_ext[PAYLOAD_W-1:0];
			out_q.queue_empty <= (count_q == '0);
			out_q.queue_full  <= is_full;
			out_q.entry_count <= count_ext[COUNT_W-1:0];
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)) ||
		(count_q + CW'(1) == $past(count_q)))
		else $error("entry count moved by more than one");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_RD) |-> (count_q != '0))
		else $error("scan started on an empty queue");

	a_chk_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_CHK) |-> ($past(state_q) == ST_SCAN_RD))
		else $error("scan check without a preceding read");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_ready) |=> !$past(out_load))
		else $error("result register overwritten while stalled");

endmodule

@@ tb/tb_skip_locked_fifo_queue.sv @@
// Self-checking testbench for the skip-locked FIFO queue: predicts every status item and compares.
module tb_skip_locked_fifo_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import slfq_pkg::*;

	localparam int unsigned DEPTH      = 16;
	localparam int unsigned FLAG_COUNT = 16;
	localparam int unsigned DATA_WIDTH = 32;

	typedef enum int {
		PH_FILL,
		PH_DRAIN,
		PH_BALANCED,
		PH_CONTEND
	} phase_t;

	// Shadow copy of the queue and its busy flags, plus the items still owed by the block.
	class queue_scoreboard;
		logic [PAYLOAD_W-1:0] slot_word [DEPTH];
		bit                   slot_guard[DEPTH];
		logic [FLAG_W-1:0]    slot_flag [DEPTH];
		bit                   busy      [FLAG_COUNT];
		int unsigned          held;
		res_t                 awaited_status[$];
		int unsigned          errors;

		function new();
			held = 0;
			errors = 0;
			foreach (busy[i])
				busy[i] = 1'b0;
		endfunction

		// Apply one accepted command to the shadow queue and queue up the status it must produce.
		function void record_item(act_t act, logic [PAYLOAD_W-1:0] word, bit guarded,
				logic [FLAG_W-1:0] flag);
			res_t r;
			bit   hit;
			int   idx;
			r = '0;
			hit = 1'b0;
			idx = 0;
			case (act)
				ACT_ENQ: begin
					if (held < DEPTH) begin
						slot_word[held]  = word;
						slot_guard[held] = guarded;
						slot_flag[held]  = flag;
						held++;
						r.accepted = 1'b1;
					end
				end
				ACT_DEQ: begin
					for (int i = 0; i < held; i++) begin
						if (!hit && (!slot_guard[i] || slot_flag[i] >= FLAG_COUNT ||
								!busy[slot_flag[i]])) begin
							hit = 1'b1;
							idx = i;
						end
					end
					if (hit) begin
						// acquire the flag of the removed entry
						if (slot_guard[idx] && slot_flag[idx] < FLAG_COUNT)
							busy[slot_flag[idx]] = 1'b1;
						r.found = 1'b1;
						r.data_out = slot_word[idx];
						for (int i = idx; i + 1 < held; i++) begin
							slot_word[i]  = slot_word[i + 1];
							slot_guard[i] = slot_guard[i + 1];
							slot_flag[i]  = slot_flag[i + 1];
						end
						held--;
					end
				end
				ACT_REL: begin
					if (flag < FLAG_COUNT) begin
						busy[flag] = 1'b0;
						r.accepted = 1'b1;
					end
				end
				default: ;
			endcase
			r.queue_empty = (held == 0);
			r.queue_full  = (held >= DEPTH);
			r.entry_count = COUNT_W'(held);
			awaited_status.push_back(r);
		endfunction

		function void compare_field(string field, logic [PAYLOAD_W-1:0] want,
				logic [PAYLOAD_W-1:0] got);
			if (got !== want) begin
				$display("%0t ns: %s mismatch, expected %0h, actual %0h",
					$time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] raw);
			res_t got;
			res_t want;
			got = res_t'(raw[$bits(res_t)-1:0]);
			if (awaited_status.size() == 0) begin
				$display("%0t ns: unexpected item, expected none, actual %0h", $time, raw);
				errors++;
				return;
			end
			want = awaited_status.pop_front();
			compare_field("accepted",    PAYLOAD_W'(want.accepted),    PAYLOAD_W'(got.accepted));
			compare_field("found",       PAYLOAD_W'(want.found),       PAYLOAD_W'(got.found));
			compare_field("data_out",    want.data_out,                got.data_out);
			compare_field("queue_empty", PAYLOAD_W'(want.queue_empty), PAYLOAD_W'(got.queue_empty));
			compare_field("queue_full",  PAYLOAD_W'(want.queue_full),  PAYLOAD_W'(got.queue_full));
			compare_field("entry_count", PAYLOAD_W'(want.entry_count), PAYLOAD_W'(got.entry_count));
		endfunction
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [ACTION_W-1:0]   s_tuser  = '0;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	queue_scoreboard sb = new();

	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int rx_stall  = 0;

	skip_locked_fifo_queue #(
		.DEPTH     (DEPTH),
		.FLAG_COUNT(FLAG_COUNT),
		.DATA_WIDTH(DATA_WIDTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #6 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side: check accepted items, then pick next ready
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			m_tready <= 1'b0;
		end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
			rx_stall <= pick_gap();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_item(act_t act, logic [PAYLOAD_W-1:0] word, bit guarded,
			logic [FLAG_W-1:0] flag);
		int unsigned gap;
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {3'b000, flag, guarded, word};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.record_item(act, word, guarded, flag);
	endtask

	// hold the sender off until the block has answered everything
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.awaited_status.size() > 0);
	endtask

	task automatic run_directed();
		send_item(ACT_ENQ, 32'h0000_0000, 1'b0, 4'd0);
		send_item(ACT_ENQ, 32'hFFFF_FFFF, 1'b1, 4'd15);
		send_item(ACT_ENQ, 32'hA5A5_5A5A, 1'b1, 4'd0);
		send_item(ACT_DEQ, 32'hFFFF_FFFF, 1'b1, 4'd15);  // unguarded head
		send_item(ACT_DEQ, 32'h0000_0000, 1'b0, 4'd0);   // takes flag 15
		send_item(ACT_ENQ, 32'h1234_5678, 1'b1, 4'd15);
		send_item(ACT_ENQ, 32'h8000_0001, 1'b1, 4'd0);
		send_item(ACT_DEQ, 32'h0000_0000, 1'b0, 4'd0);   // takes flag 0
		send_item(ACT_DEQ, 32'h0000_0000, 1'b0, 4'd0);   // both entries locked: not found
		send_item(ACT_REL, 32'hFFFF_FFFF, 1'b1, 4'd15);
		send_item(ACT_DEQ, 32'h0000_0000, 1'b0, 4'd0);   // skips nothing, flag 15 again
		send_item(ACT_DEQ, 32'h0000_0000, 1'b0, 4'd0);   // flag 0 still busy
		send_item(ACT_REL, 32'h0000_0000, 1'b0, 4'd0);
		send_item(ACT_NOP, 32'hFFFF_FFFF, 1'b1, 4'd15);
		send_item(ACT_DEQ, 32'hFFFF_FFFF, 1'b1, 4'd15);
		send_item(ACT_DEQ, 32'h0000_0000, 1'b0, 4'd0);   // empty queue
		send_item(ACT_REL, 32'h0000_0000, 1'b0, 4'd15);
		send_item(ACT_REL, 32'h0000_0000, 1'b0, 4'd0);
		wait_for_drain();
	endtask

	task automatic random_item(phase_t ph);
		int unsigned       pick;
		int unsigned       word_pick;
		act_t              act;
		logic [31:0]       word;
		bit                guarded;
		logic [FLAG_W-1:0] flag;
		pick = $urandom_range(0, 99);
		case (ph)
			PH_FILL:     act = act_t'(pick < 80 ? ACT_ENQ : pick < 90 ? ACT_DEQ :
						pick < 95 ? ACT_REL : ACT_NOP);
			PH_DRAIN:    act = act_t'(pick < 65 ? ACT_DEQ : pick < 85 ? ACT_REL :
						pick < 97 ? ACT_ENQ : ACT_NOP);
			PH_BALANCED: act = act_t'(pick < 40 ? ACT_ENQ : pick < 75 ? ACT_DEQ :
						pick < 95 ? ACT_REL : ACT_NOP);
			default:     act = act_t'(pick < 45 ? ACT_ENQ : pick < 80 ? ACT_DEQ :
						pick < 97 ? ACT_REL : ACT_NOP);
		endcase
		word_pick = $urandom_range(0, 15);
		word = word_pick == 0 ? 32'h0000_0000 : word_pick == 1 ? 32'hFFFF_FFFF : $urandom();
		if (ph == PH_CONTEND) begin
			guarded = $urandom_range(0, 9) < 9;
			flag = FLAG_W'($urandom_range(0, 1));
		end else begin
			guarded = $urandom_range(0, 9) < 7;
			// a few flags shared by many entries make skipping common
			flag = FLAG_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) :
				$urandom_range(0, 3));
		end
		send_item(act, word, guarded, flag);
	endtask

	task automatic run_random(int unsigned total);
		int unsigned sent;
		int unsigned phase_len;
		phase_t      ph;
		bit          first;
		sent = 0;
		first = 1'b1;
		while (sent < total) begin
			if (first)
				ph = PH_FILL;
			else
				ph = phase_t'($urandom_range(0, 3));
			phase_len = first ? 24 : $urandom_range(20, 80);
			tx_steady = $urandom_range(0, 4) == 0;
			rx_steady = $urandom_range(0, 4) == 0;
			repeat (phase_len) begin
				random_item(ph);
				sent++;
			end
			if (first || $urandom_range(0, 2) == 0)
				wait_for_drain();
			first = 1'b0;
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random(1400);
		wait_for_drain();
		repeat (80) @(posedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#10ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/slfq_pkg.sv
rtl/slfq_ram.sv
rtl/slfq_front.sv
rtl/slfq_cmdq.sv
rtl/slfq_back.sv
rtl/skip_locked_fifo_queue.sv
tb/tb_skip_locked_fifo_queue.sv
